// File: sv/cmsp_pkg.sv
// ----------------------------------------------------------------------------
// cmsp_pkg: shared types and constants of the color markup stream parser
// Character codes, the job record passed from the front to the back part,
// queue status and the hex digit decoder.
// ----------------------------------------------------------------------------
package cmsp_pkg;

  // Marker characters
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_C     = 8'h63;  // 'c'
  localparam logic [7:0] CH_S     = 8'h73;  // 's'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_E     = 8'h65;  // 'e'

  localparam logic [31:0] OPAQUE_ALPHA = 32'hFF00_0000;

  // Lookahead buffer: '/', 'c', 's' and five hex digits
  localparam int unsigned HELD_DEPTH = 8;
  // Results one byte can cause: all held bytes plus itself
  localparam int unsigned JOB_SLOTS  = HELD_DEPTH + 1;
  // Jobs buffered between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One burst of text results caused by one input byte
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] bytes;
    logic [3:0]                cnt;    // 1..9 results
    logic [31:0]               color;
    logic                      start;  // first result opens a segment
  } cmsp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cmsp_q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } cmsp_hex_t;

  // Decode one ASCII hex digit (0-9, a-f, A-F)
  function automatic cmsp_hex_t hex_decode(input logic [7:0] b);
    cmsp_hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h37);
    end
    return r;
  endfunction

endpackage

// File: sv/cmsp_intf.sv
// ----------------------------------------------------------------------------
// cmsp_intf: channel interfaces of the color markup stream parser
// Valid/ready channels for marked-up input bytes, text results and the
// default color write port.
// ----------------------------------------------------------------------------

// Input byte channel
interface cmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Result channel
interface cmsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [31:0] out_color;
  logic        segment_start;
  logic        run_last;

  modport source (output valid, output out_byte, output out_color,
                  output segment_start, output run_last, input ready);
  modport sink   (input valid, input out_byte, input out_color,
                  input segment_start, input run_last, output ready);
endinterface

// Default color write channel
interface cmsp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/cmsp_front.sv
// ----------------------------------------------------------------------------
// cmsp_front: marker matcher
// Takes one byte per cycle unless the queue is full, tracks marker progress
// and color in force; every byte that releases text becomes one back-part job.
// ----------------------------------------------------------------------------
module cmsp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  cmsp_in_if.sink                in_i,
  cmsp_cfg_if.sink               cfg_i,
  input  cmsp_pkg::cmsp_q_stat_t q_stat_i,
  output logic                   push_o,
  output cmsp_pkg::cmsp_job_t    job_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_SLASH = 2'd1;
  localparam logic [1:0] PH_C     = 2'd2;
  localparam logic [1:0] PH_HEX   = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [23:0] hex_q, hex_d;
  logic [31:0] color_q, color_d;
  logic [31:0] dflt_q;
  logic        pend_q, pend_d;
  logic        open_q, open_d;
  logic [7:0]  held_q [cmsp_pkg::HELD_DEPTH];

  logic        take;
  logic [7:0]  b;
  logic        last;
  logic [31:0] cur_color;
  logic [3:0]  n_res;
  logic        do_hold;
  logic [2:0]  hold_idx;
  logic        mismatch;
  logic        consume;
  cmsp_pkg::cmsp_hex_t dig;

  assign in_i.ready  = ~q_stat_i.full;
  assign cfg_i.ready = 1'b1;
  assign take        = in_i.valid & in_i.ready;
  assign b           = in_i.in_byte;
  assign last        = in_i.in_last;
  assign dig         = cmsp_pkg::hex_decode(b);
  // first byte of a stream picks up the default color
  assign cur_color   = open_q ? color_q : dflt_q;

  // Matcher next state
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    hex_d    = hex_q;
    color_d  = cur_color;
    pend_d   = pend_q;
    open_d   = 1'b1;
    n_res    = 4'd0;
    do_hold  = 1'b0;
    mismatch = 1'b0;
    consume  = 1'b0;

    unique case (phase_q)
      PH_IDLE: mismatch = 1'b1;
      PH_SLASH: begin
        if (b == cmsp_pkg::CH_C) begin
          do_hold = 1'b1;
          phase_d = PH_C;
        end else begin
          mismatch = 1'b1;
        end
      end
      PH_C: begin
        if (b == cmsp_pkg::CH_S) begin
          do_hold = 1'b1;
          phase_d = PH_HEX;
          hex_d   = '0;
        end else if (b == cmsp_pkg::CH_D) begin
          color_d = dflt_q;
          consume = 1'b1;
        end else if (b == cmsp_pkg::CH_E) begin
          consume = 1'b1;
        end else begin
          mismatch = 1'b1;
        end
      end
      PH_HEX: begin
        if (dig.ok) begin
          hex_d = {hex_q[19:0], dig.val};
          if (cnt_q[3]) begin
            // sixth digit: marker complete
            color_d = cmsp_pkg::OPAQUE_ALPHA | {8'h00, hex_q[19:0], dig.val};
            consume = 1'b1;
          end else begin
            do_hold = 1'b1;
          end
        end else begin
          mismatch = 1'b1;
        end
      end
      default: mismatch = 1'b1;
    endcase

    // release held bytes, then either hold a new '/' or emit the byte
    if (mismatch) begin
      if (b == cmsp_pkg::CH_SLASH && !last) begin
        n_res   = cnt_q;
        cnt_d   = 4'd1;
        phase_d = PH_SLASH;
      end else begin
        n_res   = cnt_q + 4'd1;
        cnt_d   = 4'd0;
        phase_d = PH_IDLE;
      end
    end

    if (do_hold) begin
      cnt_d = cnt_q + 4'd1;
      if (last) n_res = cnt_q + 4'd1;
    end

    if (consume) begin
      cnt_d   = 4'd0;
      phase_d = PH_IDLE;
      pend_d  = 1'b1;
    end

    if (n_res != 4'd0) pend_d = 1'b0;

    // end of stream flushes everything held
    if (last) begin
      cnt_d   = 4'd0;
      phase_d = PH_IDLE;
      pend_d  = 1'b1;
      open_d  = 1'b0;
    end
  end

  // a re-held '/' goes to the front of the buffer
  assign hold_idx = mismatch ? 3'd0 : cnt_q[2:0];

  // Job record: held bytes in order, then the current byte
  always_comb begin
    for (int i = 0; i < cmsp_pkg::JOB_SLOTS; i++) begin
      if (i < cmsp_pkg::HELD_DEPTH && 4'(i) < cnt_q) begin
        job_o.bytes[i] = held_q[i];
      end else begin
        job_o.bytes[i] = b;
      end
    end
    job_o.cnt   = n_res;
    job_o.color = cur_color;
    job_o.start = pend_q;
  end

  assign push_o = take & (n_res != 4'd0);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= 4'd0;
      hex_q   <= '0;
      color_q <= '0;
      pend_q  <= 1'b1;
      open_q  <= 1'b0;
      dflt_q  <= '0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        hex_q   <= hex_d;
        color_q <= color_d;
        pend_q  <= pend_d;
        open_q  <= open_d;
      end
      if (cfg_i.valid) dflt_q <= cfg_i.data;
    end
  end

  // Lookahead buffer
  always_ff @(posedge clk_i) begin
    if (take && (do_hold || (mismatch && b == cmsp_pkg::CH_SLASH && !last))) begin
      held_q[hold_idx] <= b;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd8)
    else $error("held count beyond buffer");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (cnt_q == 4'd0))
    else $error("bytes held while matcher idle");

  a_hex_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HEX) |-> (cnt_q >= 4'd3))
    else $error("hex phase without full prefix held");

endmodule

// File: sv/cmsp_queue.sv
// ----------------------------------------------------------------------------
// cmsp_queue: job queue
// Small FIFO of text jobs between the matcher and the result serializer.
// ----------------------------------------------------------------------------
module cmsp_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  cmsp_pkg::cmsp_job_t    job_i,
  input  logic                   pop_i,
  output cmsp_pkg::cmsp_job_t    head_o,
  output cmsp_pkg::cmsp_q_stat_t stat_o
);

  localparam int unsigned CNT_W = cmsp_pkg::QPTR_W + 1;

  cmsp_pkg::cmsp_job_t           slot_q [cmsp_pkg::QUEUE_DEPTH];
  logic [cmsp_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
  logic [CNT_W-1:0]              count_q;
  logic                          do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(cmsp_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = slot_q[rptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i)
    else $error("push into full job queue");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(cmsp_pkg::QUEUE_DEPTH))
    else $error("job queue level out of range");

endmodule

// File: sv/cmsp_back.sv
// ----------------------------------------------------------------------------
// cmsp_back: result serializer
// Loads one job at a time and sends its bytes one per request, flagging the
// segment start on an opening job's first result and run_last on its last.
// ----------------------------------------------------------------------------
module cmsp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmsp_pkg::cmsp_job_t    head_i,
  input  cmsp_pkg::cmsp_q_stat_t q_stat_i,
  output logic                   pop_o,
  cmsp_out_if.source             out_o
);

  cmsp_pkg::cmsp_job_t job_q;
  logic                valid_q;
  logic [3:0]          idx_q;
  logic                advance, last_res, load;

  assign advance  = valid_q & out_o.ready;
  assign last_res = (idx_q == job_q.cnt - 4'd1);
  // take the next job when idle or when the current one finishes
  assign load     = ~valid_q | (advance & last_res);
  assign pop_o    = load & ~q_stat_i.empty;

  // Result channel
  assign out_o.valid         = valid_q;
  assign out_o.out_byte      = job_q.bytes[idx_q];
  assign out_o.out_color     = job_q.color;
  assign out_o.segment_start = job_q.start & (idx_q == 4'd0);
  assign out_o.run_last      = last_res;

  // Job register and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 4'd0;
    end else if (load) begin
      valid_q <= ~q_stat_i.empty;
      idx_q   <= 4'd0;
    end else if (advance) begin
      idx_q   <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
  end

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (job_q.cnt != 4'd0 && idx_q < job_q.cnt))
    else $error("serializer position outside job");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |=> (valid_q && $stable(idx_q)))
    else $error("result moved while stalled");

endmodule

// File: sv/color_markup_stream_parser_core.sv
// ----------------------------------------------------------------------------
// color_markup_stream_parser_core: color markup stream parser
// Strips /cs, /cd and /ce color markers from a byte stream and tags each
// remaining character with its ARGB color.
// ----------------------------------------------------------------------------
// One input byte is accepted per clock as long as the job queue between the
// matcher and the serializer has room. Each byte that releases text becomes
// one job; the serializer sends one result per clock while out_o.ready is
// high, and the four-entry queue soaks up the burst of a byte that releases
// held bytes. A result passes through the queue and the serializer's job
// register before it appears. The default color register may be written at
// any time; it takes effect at the next stream start or /cd marker. Reset
// leaves no clearing pass: the block is ready the cycle after rst_ni rises.
// ----------------------------------------------------------------------------
module color_markup_stream_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmsp_in_if.sink    in_i,
  cmsp_cfg_if.sink   cfg_i,
  cmsp_out_if.source out_o
);

  cmsp_pkg::cmsp_job_t    job;
  cmsp_pkg::cmsp_job_t    head;
  cmsp_pkg::cmsp_q_stat_t q_stat;
  logic                   push;
  logic                   pop;

  // Marker matcher
  cmsp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (job)
  );

  // Job queue
  cmsp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Result serializer
  cmsp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_o    (out_o)
  );

endmodule
